// File: sv/vro_pkg.sv
// shared types and constants for the visible rectangle occlusion block
package vro_pkg;

    localparam logic [1:0] KIND_TARGET   = 2'd0;
    localparam logic [1:0] KIND_OCCLUDER = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    localparam logic [1:0] REG_SCREEN_W = 2'd0;
    localparam logic [1:0] REG_SCREEN_H = 2'd1;
    localparam logic [1:0] REG_MIN_SIZE = 2'd2;

    localparam logic [14:0] SCREEN_W_RST = 15'd1920;
    localparam logic [14:0] SCREEN_H_RST = 15'd1080;
    localparam logic [14:0] MIN_SIZE_RST = 15'd10;

    localparam int SPLIT_PARTS = 4;
    localparam int RECT_BITS   = 60;

    typedef struct packed {
        logic [14:0] h;
        logic [14:0] w;
        logic [14:0] y;
        logic [14:0] x;
    } t_rect;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OCC_RD,
        S_OCC_SPLIT,
        S_OCC_WR,
        S_OCC_FIN,
        S_EMIT_RD,
        S_EMIT_CHK,
        S_EMIT_END
    } t_state;

    typedef struct packed {
        logic tgt_load;
        logic occ_start;
        logic rd_issue;
        logic split_load;
        logic part_write;
        logic occ_fin;
        logic set_ovf;
        logic emit_start;
        logic emit_target;
        logic emit_take;
        logic v_inc;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       occ_go;
        logic       v_done;
        logic       nn_full;
        logic       mask_empty;
        logic       qualifies;
        logic       pend_v;
        logic       out_free;
        logic       ovf_emit;
    } t_status;

endpackage

// File: sv/vro_ram.sv
// generic single write port ram with registered read
module vro_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/vro_ctrl.sv
// controller state machine sequencing target, occluder and end transactions
module vro_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  vro_pkg::t_status i_status,
    output vro_pkg::t_cmd    o_cmd
);
    import vro_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_status.kind == KIND_OCCLUDER && i_status.occ_go) begin
                        n_state = S_OCC_RD;
                    end else if (i_status.kind == KIND_END) begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_OCC_RD: begin
                if (i_status.v_done || i_status.nn_full) begin
                    n_state = S_OCC_FIN;
                end else begin
                    n_state = S_OCC_SPLIT;
                end
            end
            S_OCC_SPLIT: n_state = S_OCC_WR;
            S_OCC_WR: begin
                if (i_status.mask_empty) begin
                    n_state = S_OCC_RD;
                end
            end
            S_OCC_FIN: n_state = S_IDLE;
            S_EMIT_RD: begin
                if (i_status.ovf_emit || i_status.v_done) begin
                    n_state = S_EMIT_END;
                end else begin
                    n_state = S_EMIT_CHK;
                end
            end
            S_EMIT_CHK: begin
                if (!i_status.qualifies || !i_status.pend_v || i_status.out_free) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_END: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.tgt_load   = (i_status.kind == KIND_TARGET);
                    o_cmd.occ_start  = (i_status.kind == KIND_OCCLUDER) && i_status.occ_go;
                    o_cmd.emit_start = (i_status.kind == KIND_END);
                end
            end
            S_OCC_RD: begin
                if (!i_status.v_done) begin
                    if (i_status.nn_full) begin
                        o_cmd.set_ovf = 1'b1;
                    end else begin
                        o_cmd.rd_issue = 1'b1;
                    end
                end
            end
            S_OCC_SPLIT: begin
                o_cmd.split_load = 1'b1;
                o_cmd.v_inc      = 1'b1;
            end
            S_OCC_WR: o_cmd.part_write = !i_status.mask_empty;
            S_OCC_FIN: o_cmd.occ_fin = 1'b1;
            S_EMIT_RD: begin
                if (i_status.ovf_emit) begin
                    o_cmd.emit_target = 1'b1;
                end else if (!i_status.v_done) begin
                    o_cmd.rd_issue = 1'b1;
                end
            end
            S_EMIT_CHK: begin
                if (!i_status.qualifies) begin
                    o_cmd.v_inc = 1'b1;
                end else if (!i_status.pend_v || i_status.out_free) begin
                    o_cmd.emit_take = 1'b1;
                    o_cmd.v_inc     = 1'b1;
                end
            end
            S_EMIT_END: o_cmd.emit_final = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end
endmodule

// File: sv/vro_dp.sv
// datapath: clipping, splitting, piece stores and output register
module vro_dp #(
    parameter int MAX_PIECES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [63:0]      i_s_tdata,
    input  logic [1:0]       i_s_tuser,
    input  logic [14:0]      i_screen_w,
    input  logic [14:0]      i_screen_h,
    input  logic [14:0]      i_min_size,
    input  vro_pkg::t_cmd    i_cmd,
    output vro_pkg::t_status o_status,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [63:0]      o_m_tdata,
    output logic             o_m_tuser,
    output logic             o_m_tlast
);
    import vro_pkg::*;

    localparam int AW = $clog2(MAX_PIECES);
    localparam int CW = $clog2(MAX_PIECES + 1);

    logic [CW-1:0]  r_count, r_v, r_nn;
    logic           r_ovf, r_stopped, r_bank;
    t_rect          r_tgt, r_occ, r_pend;
    logic           r_pend_v;
    t_rect          r_part [SPLIT_PARTS];
    logic [3:0]     r_mask;
    t_rect          r_out;
    logic           r_out_valid, r_out_none, r_out_last;

    // input clip
    logic signed [17:0] cx, cy, cw, ch;
    logic               clip_ok;
    t_rect              in_clipped;

    always_comb begin
        cx = {{2{i_s_tdata[15]}}, i_s_tdata[15:0]};
        cy = {{2{i_s_tdata[31]}}, i_s_tdata[31:16]};
        cw = {3'b000, i_s_tdata[46:32]};
        ch = {3'b000, i_s_tdata[61:47]};
        if (cx < 0) begin
            cw = cw + cx;
            cx = '0;
        end
        if (cy < 0) begin
            ch = ch + cy;
            cy = '0;
        end
        if (cx + cw > $signed({3'b000, i_screen_w})) begin
            cw = $signed({3'b000, i_screen_w}) - cx;
        end
        if (cy + ch > $signed({3'b000, i_screen_h})) begin
            ch = $signed({3'b000, i_screen_h}) - cy;
        end
        clip_ok      = (cw > 0) && (ch > 0);
        in_clipped.x = cx[14:0];
        in_clipped.y = cy[14:0];
        in_clipped.w = cw[14:0];
        in_clipped.h = ch[14:0];
    end

    // piece stores, ping-pong between visible and scratch role
    logic [RECT_BITS-1:0] rdata0, rdata1;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    t_rect                wr_data;
    logic                 wr_bank;
    t_rect                src;

    vro_ram #(.WIDTH(RECT_BITS), .DEPTH(MAX_PIECES)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (wr_en && !wr_bank),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_v[AW-1:0]),
        .o_rdata (rdata0)
    );

    vro_ram #(.WIDTH(RECT_BITS), .DEPTH(MAX_PIECES)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (wr_en && wr_bank),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_v[AW-1:0]),
        .o_rdata (rdata1)
    );

    assign src = r_bank ? t_rect'(rdata1) : t_rect'(rdata0);

    // split of the stored piece around the occluder
    logic [15:0]        sx2, sy2, ox2, oy2, ix, iy, ix2, iy2;
    logic signed [16:0] iw, ih;
    t_rect              part [SPLIT_PARTS];
    logic [3:0]         mask;

    always_comb begin
        sx2 = {1'b0, src.x} + {1'b0, src.w};
        sy2 = {1'b0, src.y} + {1'b0, src.h};
        ox2 = {1'b0, r_occ.x} + {1'b0, r_occ.w};
        oy2 = {1'b0, r_occ.y} + {1'b0, r_occ.h};
        ix  = (src.x > r_occ.x) ? {1'b0, src.x} : {1'b0, r_occ.x};
        iy  = (src.y > r_occ.y) ? {1'b0, src.y} : {1'b0, r_occ.y};
        ix2 = (sx2 < ox2) ? sx2 : ox2;
        iy2 = (sy2 < oy2) ? sy2 : oy2;
        iw  = $signed({1'b0, ix2}) - $signed({1'b0, ix});
        ih  = $signed({1'b0, iy2}) - $signed({1'b0, iy});
        part[0] = src;
        part[0].w = 15'(ix - {1'b0, src.x});
        part[1].x = ix2[14:0];
        part[1].y = src.y;
        part[1].w = 15'(sx2 - ix2);
        part[1].h = src.h;
        part[2].x = ix[14:0];
        part[2].y = src.y;
        part[2].w = iw[14:0];
        part[2].h = 15'(iy - {1'b0, src.y});
        part[3].x = ix[14:0];
        part[3].y = iy2[14:0];
        part[3].w = iw[14:0];
        part[3].h = 15'(sy2 - iy2);
        if (iw <= 0 || ih <= 0) begin
            part[0] = src;
            mask    = 4'b0001;
        end else begin
            mask = {sy2 > iy2, iy > {1'b0, src.y}, sx2 > ix2, ix > {1'b0, src.x}};
        end
    end

    // lowest pending part goes out first
    t_rect      sel_part;
    logic [3:0] sel_bit;

    always_comb begin
        priority if (r_mask[0]) begin
            sel_part = r_part[0];
            sel_bit  = 4'b0001;
        end else if (r_mask[1]) begin
            sel_part = r_part[1];
            sel_bit  = 4'b0010;
        end else if (r_mask[2]) begin
            sel_part = r_part[2];
            sel_bit  = 4'b0100;
        end else begin
            sel_part = r_part[3];
            sel_bit  = 4'b1000;
        end
    end

    always_comb begin
        wr_en   = (i_cmd.tgt_load && clip_ok) || i_cmd.part_write;
        wr_bank = i_cmd.part_write ? !r_bank : r_bank;
        wr_addr = i_cmd.part_write ? r_nn[AW-1:0] : '0;
        wr_data = i_cmd.part_write ? sel_part : in_clipped;
    end

    logic out_free, out_load;
    assign out_free = !r_out_valid || i_m_tready;
    assign out_load = (i_cmd.emit_take && r_pend_v) || i_cmd.emit_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_v         <= '0;
            r_nn        <= '0;
            r_ovf       <= 1'b0;
            r_stopped   <= 1'b0;
            r_bank      <= 1'b0;
            r_tgt       <= '0;
            r_pend_v    <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tgt_load) begin
                r_ovf     <= 1'b0;
                r_tgt     <= clip_ok ? in_clipped : '0;
                r_count   <= clip_ok ? CW'(1) : '0;
                r_stopped <= !clip_ok;
            end
            if (i_cmd.occ_start || i_cmd.emit_start) begin
                r_v      <= '0;
                r_nn     <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.v_inc) begin
                r_v <= r_v + CW'(1);
            end
            if (i_cmd.split_load) begin
                r_mask <= mask;
            end
            if (i_cmd.part_write) begin
                r_mask <= r_mask & ~sel_bit;
                r_nn   <= r_nn + CW'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.occ_fin) begin
                r_count <= r_nn;
                r_bank  <= !r_bank;
                if (r_ovf || r_nn == '0) begin
                    r_stopped <= 1'b1;
                end
            end
            if (i_cmd.emit_target || i_cmd.emit_take) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.emit_final) begin
                r_count   <= '0;
                r_ovf     <= 1'b0;
                r_tgt     <= '0;
                r_stopped <= 1'b1;
                r_pend_v  <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.occ_start) begin
            r_occ <= in_clipped;
        end
        if (i_cmd.split_load) begin
            r_part <= part;
        end
        if (i_cmd.emit_target) begin
            r_pend <= r_tgt;
        end else if (i_cmd.emit_take) begin
            r_pend <= src;
        end
        if (out_load) begin
            r_out_last <= i_cmd.emit_final;
            r_out_none <= i_cmd.emit_final && !r_pend_v;
            r_out      <= (i_cmd.emit_final && !r_pend_v) ? '0 : r_pend;
        end
    end

    always_comb begin
        o_status.kind       = i_s_tuser;
        o_status.occ_go     = !r_stopped && clip_ok;
        o_status.v_done     = (r_v == r_count);
        o_status.nn_full    = (r_nn >= CW'(MAX_PIECES - SPLIT_PARTS));
        o_status.mask_empty = (r_mask == '0);
        o_status.qualifies  = (src.w > i_min_size) && (src.h > i_min_size);
        o_status.pend_v     = r_pend_v;
        o_status.out_free   = out_free;
        o_status.ovf_emit   = r_ovf && (r_count != '0);
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.h, r_out.w, r_out.y, r_out.x};
    assign o_m_tuser  = r_out_none;
    assign o_m_tlast  = r_out_last;
endmodule

// File: sv/visible_rect_occlusion_top.sv
// top level: config registers, controller and datapath of the occlusion block
//
// Computes the visible part of one target rectangle under a series of
// occluders. The input stream carries one rectangle per transaction with
// its kind in s_tuser: target starts a new visible set, occluder cuts it,
// end emits the set. Results leave on the output stream, one rectangle per
// transaction, m_tuser set when nothing is visible, m_tlast on the final one.
// Screen size and minimum emitted size are written over the apb port.
// Target and unknown kinds need no walk; an occluder walks the stored
// pieces one at a time through the piece ram, reading, splitting and
// writing the parts of each; an end fetches each stored piece from the
// ram and checks it in turn.
// A stalled output holds its register; the walk pauses until the result
// register frees, while a finished result never blocks the next input.
// Reset clears the set and restores the default screen of 1920 by 1080.
module visible_rect_occlusion_top #(
    parameter int MAX_PIECES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rect_x, rect_y, rect_w, rect_h, zero fill
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_x, out_y, out_w, out_h, zero fill
    output logic        m_tuser,   // none_visible
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vro_pkg::*;

    logic [14:0] r_screen_w, r_screen_h, r_min_size;
    t_cmd        cmd;
    t_status     status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RST;
            r_screen_h <= SCREEN_H_RST;
            r_min_size <= MIN_SIZE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_SCREEN_W: r_screen_w <= pwdata[14:0];
                REG_SCREEN_H: r_screen_h <= pwdata[14:0];
                REG_MIN_SIZE: r_min_size <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SCREEN_W: prdata = {17'd0, r_screen_w};
            REG_SCREEN_H: prdata = {17'd0, r_screen_h};
            REG_MIN_SIZE: prdata = {17'd0, r_min_size};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    vro_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vro_dp #(.MAX_PIECES(MAX_PIECES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_screen_w (r_screen_w),
        .i_screen_h (r_screen_h),
        .i_min_size (r_min_size),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );
endmodule
